>>> rtl/dlq_pkg.sv
// Shared types and constants of the doubly linked queue manager.
package dlq_pkg;

    localparam int NODES   = 256;
    localparam int NODE_W  = $clog2(NODES);
    localparam int LINK_W  = NODE_W + 1;
    localparam int COUNT_W = 9;
    localparam int LEN_W   = 9;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 24;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NODES);

    localparam logic [2:0] REQ_INS_TAIL  = 3'd0;
    localparam logic [2:0] REQ_INS_GROUP = 3'd1;
    localparam logic [2:0] REQ_PEEK_TAIL = 3'd2;
    localparam logic [2:0] REQ_RM_HEAD   = 3'd3;
    localparam logic [2:0] REQ_RM_TAIL   = 3'd4;
    localparam logic [2:0] REQ_UNLINK    = 3'd5;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOTNODE = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_RANGE,
        K_INSERT,
        K_PEEK,
        K_RM_HEAD,
        K_RM_TAIL,
        K_UNLINK
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [NODE_W-1:0]  node;
        logic [LEN_W-1:0]   len;
    } op_t;

endpackage

>>> rtl/dlq_front.sv
// Request intake: classifies each request and holds it in a two-entry queue.
module dlq_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [dlq_pkg::IN_W-1:0] s_tdata,
    output logic                    op_valid,
    output dlq_pkg::op_t            op,
    input  logic                    op_pop
);

    logic [2:0]                 req;
    logic [dlq_pkg::NODE_W-1:0] id;
    logic [dlq_pkg::LEN_W-1:0]  len;
    dlq_pkg::op_t               cls;
    logic [dlq_pkg::LEN_W:0]    span;

    dlq_pkg::op_t q_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   fill_reg;
    logic         push;

    assign req  = s_tdata[2:0];
    assign id   = s_tdata[10:3];
    assign len  = s_tdata[19:11];
    assign span = {2'b00, id} + {1'b0, len};

    always_comb
    begin
        cls.node = id;
        cls.len  = len;
        case (req)
            dlq_pkg::REQ_INS_TAIL:
            begin
                cls.kind = dlq_pkg::K_INSERT;
                cls.len  = dlq_pkg::LEN_W'(1);
            end
            dlq_pkg::REQ_INS_GROUP:
            begin
                if (len == '0)
                    cls.kind = dlq_pkg::K_NOP;
                else if (span > (dlq_pkg::LEN_W+1)'(dlq_pkg::NODES))
                    cls.kind = dlq_pkg::K_RANGE;
                else
                    cls.kind = dlq_pkg::K_INSERT;
            end
            dlq_pkg::REQ_PEEK_TAIL: cls.kind = dlq_pkg::K_PEEK;
            dlq_pkg::REQ_RM_HEAD:   cls.kind = dlq_pkg::K_RM_HEAD;
            dlq_pkg::REQ_RM_TAIL:   cls.kind = dlq_pkg::K_RM_TAIL;
            dlq_pkg::REQ_UNLINK:    cls.kind = dlq_pkg::K_UNLINK;
            default:                cls.kind = dlq_pkg::K_NOP;
        endcase
    end

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign op_valid = (fill_reg != 2'd0);
    assign op       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (op_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(op_pop);
        end
    end

endmodule

>>> rtl/dlq_back.sv
// Link engine: link memories, head, tail, count and the result register.
module dlq_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     op_valid,
    input  dlq_pkg::op_t             op,
    output logic                     op_pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [dlq_pkg::OUT_W-1:0] m_tdata
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_INS_A = 6'b001000,
        S_INS_B = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    localparam int NW = dlq_pkg::NODE_W;
    localparam int LW = dlq_pkg::LINK_W;
    localparam int CW = dlq_pkg::COUNT_W;

    state_t              state_reg, state_next;
    dlq_pkg::kind_t      kind_reg, kind_next;
    logic [NW-1:0]       tgt_reg, tgt_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    dlq_pkg::status_t    res_st_reg, res_st_next;
    logic                res_nv_reg, res_nv_next;

    logic                out_valid_reg;
    logic [dlq_pkg::OUT_W-1:0] out_data_reg;

    logic [LW-1:0] next_mem [dlq_pkg::NODES];
    logic [LW-1:0] prev_mem [dlq_pkg::NODES];
    logic          vld_reg  [dlq_pkg::NODES];
    logic [LW-1:0] nq_reg, pq_reg;
    logic          vq_reg;
    logic [LW-1:0] nx, pv, tgt_link;

    logic          nwe, pwe, ins_we;
    logic [NW-1:0] nwa, pwa;
    logic [LW-1:0] nwd, pwd;
    logic          out_free;

    assign nx       = vq_reg ? nq_reg : dlq_pkg::NULL_LINK;
    assign pv       = vq_reg ? pq_reg : dlq_pkg::NULL_LINK;
    assign tgt_link = {1'b0, tgt_reg};
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        tgt_next    = tgt_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        res_st_next = res_st_reg;
        res_nv_next = res_nv_reg;
        op_pop      = 1'b0;
        nwe = 1'b0; nwa = tgt_reg; nwd = dlq_pkg::NULL_LINK;
        pwe = 1'b0; pwa = tgt_reg; pwd = dlq_pkg::NULL_LINK;
        ins_we = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop      = 1'b1;
                    kind_next   = op.kind;
                    tgt_next    = op.node;
                    len_next    = op.len;
                    rem_next    = op.len;
                    res_st_next = dlq_pkg::ST_OK;
                    res_nv_next = 1'b0;
                    case (op.kind)
                        dlq_pkg::K_NOP:    state_next = S_OUT;
                        dlq_pkg::K_RANGE:
                        begin
                            res_st_next = dlq_pkg::ST_RANGE;
                            state_next  = S_OUT;
                        end
                        dlq_pkg::K_INSERT: state_next = S_INS_A;
                        dlq_pkg::K_UNLINK: state_next = S_READ;
                        default:
                        begin
                            // peek and both removes look at an end of the queue
                            tgt_next = (op.kind == dlq_pkg::K_RM_HEAD) ?
                                       head_reg[NW-1:0] : tail_reg[NW-1:0];
                            if (head_reg == dlq_pkg::NULL_LINK)
                            begin
                                res_st_next = dlq_pkg::ST_EMPTY;
                                state_next  = S_OUT;
                            end
                            else if (((op.kind == dlq_pkg::K_RM_HEAD) ?
                                      head_reg[NW] : tail_reg[NW]))
                            begin
                                res_st_next = dlq_pkg::ST_NOTNODE;
                                state_next  = S_OUT;
                            end
                            else
                                state_next = S_READ;
                        end
                    endcase
                end
            end
            S_READ: state_next = S_EVAL;
            S_EVAL:
            begin
                state_next  = S_OUT;
                res_st_next = dlq_pkg::ST_NOTNODE;
                case (kind_reg)
                    dlq_pkg::K_PEEK:
                    begin
                        if (nx == dlq_pkg::NULL_LINK)
                            res_st_next = dlq_pkg::ST_OK;
                    end
                    dlq_pkg::K_RM_HEAD:
                    begin
                        if (pv == dlq_pkg::NULL_LINK)
                        begin
                            if (nx != dlq_pkg::NULL_LINK)
                            begin
                                pwe = 1'b1; pwa = nx[NW-1:0];
                                head_next   = nx;
                                res_st_next = dlq_pkg::ST_OK;
                            end
                            else if (tail_reg == tgt_link)
                            begin
                                head_next   = dlq_pkg::NULL_LINK;
                                tail_next   = dlq_pkg::NULL_LINK;
                                res_st_next = dlq_pkg::ST_OK;
                            end
                        end
                    end
                    dlq_pkg::K_RM_TAIL:
                    begin
                        if (nx == dlq_pkg::NULL_LINK)
                        begin
                            if (pv != dlq_pkg::NULL_LINK)
                            begin
                                nwe = 1'b1; nwa = pv[NW-1:0];
                                tail_next   = pv;
                                res_st_next = dlq_pkg::ST_OK;
                            end
                            else if (head_reg == tgt_link)
                            begin
                                head_next   = dlq_pkg::NULL_LINK;
                                tail_next   = dlq_pkg::NULL_LINK;
                                res_st_next = dlq_pkg::ST_OK;
                            end
                        end
                    end
                    default:
                    begin
                        if (nx != dlq_pkg::NULL_LINK && pv != dlq_pkg::NULL_LINK)
                        begin
                            pwe = 1'b1; pwa = nx[NW-1:0]; pwd = pv;
                            nwe = 1'b1; nwa = pv[NW-1:0]; nwd = nx;
                            res_st_next = dlq_pkg::ST_OK;
                        end
                        else if (nx != dlq_pkg::NULL_LINK)
                        begin
                            if (head_reg == tgt_link)
                            begin
                                pwe = 1'b1; pwa = nx[NW-1:0];
                                head_next   = nx;
                                res_st_next = dlq_pkg::ST_OK;
                            end
                        end
                        else if (pv != dlq_pkg::NULL_LINK)
                        begin
                            if (tail_reg == tgt_link)
                            begin
                                nwe = 1'b1; nwa = pv[NW-1:0];
                                tail_next   = pv;
                                res_st_next = dlq_pkg::ST_OK;
                            end
                        end
                        else if (head_reg == tgt_link && tail_reg == tgt_link)
                        begin
                            head_next   = dlq_pkg::NULL_LINK;
                            tail_next   = dlq_pkg::NULL_LINK;
                            res_st_next = dlq_pkg::ST_OK;
                        end
                    end
                endcase
                if (res_st_next == dlq_pkg::ST_OK)
                begin
                    res_nv_next = 1'b1;
                    if (kind_reg != dlq_pkg::K_PEEK)
                        count_next = count_reg - CW'(1);
                end
            end
            S_INS_A:
            begin
                // fresh node: next is null, prev is the old tail
                ins_we = 1'b1;
                nwe = 1'b1;
                pwe = 1'b1;
                pwd = (head_reg != dlq_pkg::NULL_LINK) ? tail_reg : dlq_pkg::NULL_LINK;
                state_next = S_INS_B;
            end
            S_INS_B:
            begin
                if (head_reg != dlq_pkg::NULL_LINK)
                begin
                    nwe = 1'b1; nwa = tail_reg[NW-1:0]; nwd = tgt_link;
                end
                else
                    head_next = tgt_link;
                tail_next = tgt_link;
                rem_next  = rem_reg - CW'(1);
                tgt_next  = tgt_reg + NW'(1);
                if (rem_reg == CW'(1))
                begin
                    count_next = count_reg + len_reg;
                    state_next = S_OUT;
                end
                else
                    state_next = S_INS_A;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nwe)
            next_mem[nwa] <= nwd;
        if (pwe)
            prev_mem[pwa] <= pwd;
        nq_reg <= next_mem[tgt_reg];
        pq_reg <= prev_mem[tgt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dlq_pkg::NODES; i++)
                vld_reg[i] <= 1'b0;
            vq_reg <= 1'b0;
        end
        else
        begin
            if (ins_we)
                vld_reg[tgt_reg] <= 1'b1;
            vq_reg <= vld_reg[tgt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        tgt_reg    <= tgt_next;
        len_reg    <= len_next;
        rem_reg    <= rem_next;
        res_st_reg <= res_st_next;
        res_nv_reg <= res_nv_next;
        if (state_reg == S_OUT && out_free)
            out_data_reg <= {4'b0000, res_nv_reg,
                             res_nv_reg ? tgt_reg : NW'(0),
                             count_reg, res_st_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= dlq_pkg::NULL_LINK;
            tail_reg      <= dlq_pkg::NULL_LINK;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_ends_null_together: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg[NW] == tail_reg[NW])
        else $error("head and tail disagree on empty");

    a_insert_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_A |=> state_reg == S_INS_B)
        else $error("insert write phase skipped");

    a_insert_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_A || state_reg == S_INS_B) |-> rem_reg != '0)
        else $error("insert walk with nothing left");

endmodule

>>> rtl/doubly_linked_queue_manager.sv
// Top level of the doubly linked queue manager.
// Requests are taken one at a time and each returns exactly one result.
// Empty, range-refused, zero-length and unknown requests go straight to the
// result register; peek, removes and unlink first do one registered read of
// the link memories and then, for removes and unlink, one write-back; an
// insert writes each node in two steps, the new node's links and then the
// old tail's next link.
// A two-entry request queue lets the next request be accepted while one is
// being worked on, and the result register holds a finished result until
// it is taken. Unwritten link entries read as null via valid bits, no clearing pass.
module doubly_linked_queue_manager (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // req_type[2:0], node_id[10:3], group_length[19:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], entry_count[10:2], node_out[18:11],
                                   // node_valid[19]
);

    logic         op_valid;
    logic         op_pop;
    dlq_pkg::op_t op;

    dlq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop)
    );

    dlq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
